FILE: rtl/core/yuyv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// yuyv2rgb_pkg
// Shared types and constants of the YUYV to RGB pixel converter.
// ----------------------------------------------------------------------------
package yuyv2rgb_pkg;

   localparam int BYTE_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // configuration register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRAY_MODE    = 2'd0,
      CSR_FRAME_WIDTH  = 2'd1,
      CSR_FRAME_HEIGHT = 2'd2
   } csr_index_type;

   localparam logic [CSR_DATA_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [CSR_DATA_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   // state of the input register stage
   typedef struct packed {
      logic valid;   // a pair (or gray sample) is held
      logic gray;    // held transaction is grayscale
      logic second;  // first pixel already sent, second pending
   } front_status_type;

   // position flags of the pixel about to be sent
   typedef struct packed {
      logic end_of_line;
      logic end_of_frame;
   } pos_flags_type;

endpackage

FILE: rtl/core/yuyv2rgb_front.sv
// ----------------------------------------------------------------------------
// yuyv2rgb_front
// Input register stage: captures a transaction and the chroma terms.
// ----------------------------------------------------------------------------
module yuyv2rgb_front
   import yuyv2rgb_pkg::*;
#(
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [BYTE_W-1:0]          req_first_luma,
   input  logic [BYTE_W-1:0]          req_blue_chroma,
   input  logic [BYTE_W-1:0]          req_second_luma,
   input  logic [BYTE_W-1:0]          req_red_chroma,
   input  logic                       gray_mode,
   input  logic                       advance,
   output front_status_type           status,
   output logic [BYTE_W-1:0]          luma,
   output logic signed [COEF_FRAC_BITS+10:0] red_term,
   output logic signed [COEF_FRAC_BITS+10:0] green_term,
   output logic signed [COEF_FRAC_BITS+10:0] blue_term
);

   localparam int KW     = COEF_FRAC_BITS + 3;
   localparam int TERM_W = COEF_FRAC_BITS + 11;
   localparam longint SCALE = longint'(1) << COEF_FRAC_BITS;
   localparam logic signed [KW-1:0] K_RV = KW'((128033 * SCALE + 50000) / 100000);
   localparam logic signed [KW-1:0] K_GU = KW'((21482 * SCALE + 50000) / 100000);
   localparam logic signed [KW-1:0] K_GV = KW'((38059 * SCALE + 50000) / 100000);
   localparam logic signed [KW-1:0] K_BU = KW'((212798 * SCALE + 50000) / 100000);

   logic                     valid_ff, valid_in;
   logic                     gray_ff, second_ff, second_in;
   logic [BYTE_W-1:0]        y0_ff, y1_ff;
   logic signed [TERM_W-1:0] rv_ff, g_ff, bu_ff;
   logic signed [BYTE_W-1:0] du, dv;
   logic signed [TERM_W-1:0] prod_rv, prod_gu, prod_gv, prod_bu;
   logic                     done, load;

   // subtracting 128 from a byte is a flip of its top bit
   assign du = $signed({~req_blue_chroma[BYTE_W-1], req_blue_chroma[BYTE_W-2:0]});
   assign dv = $signed({~req_red_chroma[BYTE_W-1], req_red_chroma[BYTE_W-2:0]});

   assign prod_rv = K_RV * dv;
   assign prod_gu = K_GU * du;
   assign prod_gv = K_GV * dv;
   assign prod_bu = K_BU * du;

   assign done      = advance && (gray_ff || second_ff);
   assign req_ready = !valid_ff || done;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in  = valid_ff;
      second_in = second_ff;
      if (load) begin
         valid_in  = 1'b1;
         second_in = 1'b0;
      end else if (done) begin
         valid_in  = 1'b0;
         second_in = 1'b0;
      end else if (advance) begin
         second_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         gray_ff <= gray_mode;
         y0_ff   <= req_first_luma;
         y1_ff   <= req_second_luma;
         rv_ff   <= prod_rv;
         g_ff    <= -prod_gu - prod_gv;
         bu_ff   <= prod_bu;
      end
   end

   assign status     = '{valid: valid_ff, gray: gray_ff, second: second_ff};
   assign luma       = second_ff ? y1_ff : y0_ff;
   assign red_term   = rv_ff;
   assign green_term = g_ff;
   assign blue_term  = bu_ff;

endmodule

FILE: rtl/core/yuyv2rgb_pixel_math.sv
// ----------------------------------------------------------------------------
// yuyv2rgb_pixel_math
// Adds luma to the chroma terms and clamps each channel to a byte.
// ----------------------------------------------------------------------------
module yuyv2rgb_pixel_math
   import yuyv2rgb_pkg::*;
#(
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic                              gray,
   input  logic [BYTE_W-1:0]                 luma,
   input  logic signed [COEF_FRAC_BITS+10:0] red_term,
   input  logic signed [COEF_FRAC_BITS+10:0] green_term,
   input  logic signed [COEF_FRAC_BITS+10:0] blue_term,
   output logic [BYTE_W-1:0]                 red,
   output logic [BYTE_W-1:0]                 green,
   output logic [BYTE_W-1:0]                 blue
);

   localparam int SUM_W = COEF_FRAC_BITS + 12;

   logic signed [SUM_W-1:0] base, sum_r, sum_g, sum_b;
   logic [BYTE_W-1:0]       clip_r, clip_g, clip_b;

   function automatic logic [BYTE_W-1:0] clamp_byte(input logic signed [SUM_W-1:0] s);
      logic [SUM_W-COEF_FRAC_BITS-2:0] q;
      q = s[SUM_W-2:COEF_FRAC_BITS];
      if (s[SUM_W-1] || (s == '0))
         return '0;
      else if (|q[SUM_W-COEF_FRAC_BITS-2:BYTE_W])
         return '1;
      else
         return q[BYTE_W-1:0];
   endfunction

   assign base  = $signed({4'b0, luma, {COEF_FRAC_BITS{1'b0}}});
   assign sum_r = base + $signed({red_term[COEF_FRAC_BITS+10], red_term});
   assign sum_g = base + $signed({green_term[COEF_FRAC_BITS+10], green_term});
   assign sum_b = base + $signed({blue_term[COEF_FRAC_BITS+10], blue_term});

   assign clip_r = clamp_byte(sum_r);
   assign clip_g = clamp_byte(sum_g);
   assign clip_b = clamp_byte(sum_b);

   assign red   = gray ? luma : clip_r;
   assign green = gray ? luma : clip_g;
   assign blue  = gray ? luma : clip_b;

endmodule

FILE: rtl/core/yuyv2rgb_position.sv
// ----------------------------------------------------------------------------
// yuyv2rgb_position
// Column and row counters that flag the last pixel of a line and frame.
// ----------------------------------------------------------------------------
module yuyv2rgb_position
   import yuyv2rgb_pkg::*;
#(
   parameter int MAX_DIM = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CSR_DATA_W-1:0] frame_width,
   input  logic [CSR_DATA_W-1:0] frame_height,
   input  logic                  advance,
   output pos_flags_type         flags
);

   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int DIM_W = ($clog2(MAX_DIM + 1) > CSR_DATA_W) ?
                          $clog2(MAX_DIM + 1) : CSR_DATA_W;

   logic [CNT_W-1:0] column_ff, column_in, row_ff, row_in;
   logic [DIM_W-1:0] fw, fh, w_eff, h_eff;
   logic             eol, eof;

   assign fw = DIM_W'(frame_width);
   assign fh = DIM_W'(frame_height);

   always_comb begin
      if (fw < DIM_W'(2))
         w_eff = DIM_W'(2);
      else if (fw > DIM_W'(MAX_DIM))
         w_eff = DIM_W'(MAX_DIM);
      else
         w_eff = fw;
      if (fh < DIM_W'(1))
         h_eff = DIM_W'(1);
      else if (fh > DIM_W'(MAX_DIM))
         h_eff = DIM_W'(MAX_DIM);
      else
         h_eff = fh;
   end

   // counts past the size (after a size change) still count as last
   assign eol = DIM_W'(column_ff) >= (w_eff - DIM_W'(1));
   assign eof = eol && (DIM_W'(row_ff) >= (h_eff - DIM_W'(1)));

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (advance) begin
         if (eol) begin
            column_in = '0;
            row_in    = eof ? '0 : row_ff + CNT_W'(1);
         end else begin
            column_in = column_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   assign flags = '{end_of_line: eol, end_of_frame: eof};

endmodule

FILE: rtl/core/yuyv_to_rgb_pixel_converter_top.sv
// ----------------------------------------------------------------------------
// yuyv_to_rgb_pixel_converter_top
// YUYV 4:2:2 pixel pair to RGB888 converter with line and frame markers.
// ----------------------------------------------------------------------------
// Usage:
//  - req_*: one transaction carries a packed Y0,U,Y1,V pair (valid/ready).
//    In color mode it yields two RGB pixels, in gray mode one pixel with
//    R=G=B=first_luma.
//  - rsp_*: one transaction per pixel. last_of_item marks the final pixel
//    of a request; end_of_line / end_of_frame come from the frame counters.
//  - csr_*: register writes (gray mode, width, height); always ready.
//    Write only while the block is idle.
// Path: a request is taken into the input register, and each of its pixels
// then moves to the output register, from which rsp presents it.
// The output register sends one pixel per cycle while rsp_ready is high.
// The next request is taken in the cycle its predecessor's last pixel
// moves to the output register.
// Reset clears the valids and the column/row counters and loads
// gray_mode=0, width=640, height=480. When rsp_ready is low the output
// register holds its pixel, one request waits in the input register, and
// req_ready drops.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_pixel_converter_top
   import yuyv2rgb_pkg::*;
#(
   parameter int COEF_FRAC_BITS = 14,
   parameter int MAX_DIM        = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [BYTE_W-1:0]     req_first_luma,
   input  logic [BYTE_W-1:0]     req_blue_chroma,
   input  logic [BYTE_W-1:0]     req_second_luma,
   input  logic [BYTE_W-1:0]     req_red_chroma,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BYTE_W-1:0]     rsp_red,
   output logic [BYTE_W-1:0]     rsp_green,
   output logic [BYTE_W-1:0]     rsp_blue,
   output logic                  rsp_last_of_item,
   output logic                  rsp_end_of_line,
   output logic                  rsp_end_of_frame
);

   localparam int TERM_W = COEF_FRAC_BITS + 11;

   // configuration registers
   logic                  gray_mode_ff, gray_mode_in;
   logic [CSR_DATA_W-1:0] frame_width_ff, frame_width_in;
   logic [CSR_DATA_W-1:0] frame_height_ff, frame_height_in;

   // input stage to output stage
   front_status_type         front_st;
   logic [BYTE_W-1:0]        luma;
   logic signed [TERM_W-1:0] red_term, green_term, blue_term;
   logic [BYTE_W-1:0]        pix_r, pix_g, pix_b;
   pos_flags_type            pos;
   logic                     out_load;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]        red_ff, green_ff, blue_ff;
   logic                     last_ff, eol_ff, eof_ff;

   // ---------------------------------------------------------------------
   // Register file
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      gray_mode_in    = gray_mode_ff;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GRAY_MODE:    gray_mode_in    = csr_wdata[0];
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata;
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gray_mode_ff    <= 1'b0;
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         gray_mode_ff    <= gray_mode_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // ---------------------------------------------------------------------
   // Input register with chroma products
   // ---------------------------------------------------------------------
   yuyv2rgb_front #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_first_luma  (req_first_luma),
      .req_blue_chroma (req_blue_chroma),
      .req_second_luma (req_second_luma),
      .req_red_chroma  (req_red_chroma),
      .gray_mode       (gray_mode_ff),
      .advance         (out_load),
      .status          (front_st),
      .luma            (luma),
      .red_term        (red_term),
      .green_term      (green_term),
      .blue_term       (blue_term)
   );

   // ---------------------------------------------------------------------
   // Per-pixel add and clamp
   // ---------------------------------------------------------------------
   yuyv2rgb_pixel_math #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_math (
      .gray       (front_st.gray),
      .luma       (luma),
      .red_term   (red_term),
      .green_term (green_term),
      .blue_term  (blue_term),
      .red        (pix_r),
      .green      (pix_g),
      .blue       (pix_b)
   );

   // ---------------------------------------------------------------------
   // Frame position, advanced once per pixel entering the output register
   // ---------------------------------------------------------------------
   yuyv2rgb_position #(
      .MAX_DIM (MAX_DIM)
   ) u_pos (
      .clock        (clock),
      .reset        (reset),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .advance      (out_load),
      .flags        (pos)
   );

   // ---------------------------------------------------------------------
   // Output register: refills when empty or when the receiver takes it
   // ---------------------------------------------------------------------
   assign out_load = front_st.valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         red_ff   <= pix_r;
         green_ff <= pix_g;
         blue_ff  <= pix_b;
         last_ff  <= front_st.gray || front_st.second;
         eol_ff   <= pos.end_of_line;
         eof_ff   <= pos.end_of_frame;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red          = red_ff;
   assign rsp_green        = green_ff;
   assign rsp_blue         = blue_ff;
   assign rsp_last_of_item = last_ff;
   assign rsp_end_of_line  = eol_ff;
   assign rsp_end_of_frame = eof_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // end of frame only ever falls on an end of line
   a_eof_on_eol: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_end_of_frame || rsp_end_of_line))
      else $error("end_of_frame without end_of_line");

   // an accepted request is held in the input register next cycle
   a_req_held: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> front_st.valid)
      else $error("accepted request lost");

   // after the first pixel of a color pair the second is still pending
   a_pair_second: assert property (@(posedge clock) disable iff (reset)
      (out_load && !front_st.gray && !front_st.second)
      |=> (front_st.valid && front_st.second && !req_ready == (rsp_valid && !rsp_ready)))
      else $error("color pair second pixel not pending");

   // a gray pixel or a pair's second pixel is always marked last
   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_last_of_item == $past(front_st.gray || front_st.second)))
      else $error("last_of_item mismatch");

endmodule

FILE: dv/yuyv_pixel_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// yuyv_pixel_check_pkg
// Expected-pixel predictor and scoreboard for the YUYV to RGB converter bench.
// ----------------------------------------------------------------------------
package yuyv_pixel_check_pkg;
   import yuyv2rgb_pkg::*;

   localparam int FRAC_BITS = 14;
   localparam int DIM_LIMIT = 4096;

   // coefficient magnitudes, scaled by 2^14 and rounded to nearest
   localparam int RED_FROM_V   = 20977;
   localparam int GREEN_FROM_U = 3520;
   localparam int GREEN_FROM_V = 6236;
   localparam int BLUE_FROM_U  = 34865;
   localparam int CHROMA_ZERO  = 128;

   // index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
      logic              last_of_item;
      logic              end_of_line;
      logic              end_of_frame;
   } rgb_pixel_type;

   class rgb_pixel_scoreboard;
      logic          gray_mode;
      int            frame_width;
      int            frame_height;
      int            column;
      int            row;
      rgb_pixel_type expected_pixels[$];
      int            mismatch_count;

      function new();
         gray_mode      = 1'b0;
         frame_width    = int'(FRAME_WIDTH_RESET);
         frame_height   = int'(FRAME_HEIGHT_RESET);
         column         = 0;
         row            = 0;
         mismatch_count = 0;
      endfunction

      function void write_register(input logic [CSR_IDX_W-1:0] index,
                                   input logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_GRAY_MODE:    gray_mode = data[0];
            CSR_FRAME_WIDTH:  frame_width = int'(data);
            CSR_FRAME_HEIGHT: frame_height = int'(data);
            default: ;
         endcase
      endfunction

      static function logic [BYTE_W-1:0] saturate(input int acc);
         int quotient;
         if (acc <= 0)
            return '0;
         quotient = acc >>> FRAC_BITS;
         return (quotient > 255) ? 8'd255 : quotient[BYTE_W-1:0];
      endfunction

      static function string describe(input rgb_pixel_type px);
         return $sformatf("rgb=%0d/%0d/%0d last=%0b eol=%0b eof=%0b", px.red, px.green,
                          px.blue, px.last_of_item, px.end_of_line, px.end_of_frame);
      endfunction

      // flags come from the position counters, clamped frame size applies
      function void push_pixel(input logic [BYTE_W-1:0] r, input logic [BYTE_W-1:0] g,
                               input logic [BYTE_W-1:0] b, input logic last);
         int            eff_width;
         int            eff_height;
         rgb_pixel_type px;
         eff_width  = (frame_width < 2) ? 2 :
                      (frame_width > DIM_LIMIT) ? DIM_LIMIT : frame_width;
         eff_height = (frame_height < 1) ? 1 :
                      (frame_height > DIM_LIMIT) ? DIM_LIMIT : frame_height;
         px.red          = r;
         px.green        = g;
         px.blue         = b;
         px.last_of_item = last;
         px.end_of_line  = (column >= eff_width - 1);
         px.end_of_frame = px.end_of_line && (row >= eff_height - 1);
         if (px.end_of_line) begin
            column = 0;
            row    = px.end_of_frame ? 0 : row + 1;
         end else begin
            column++;
         end
         expected_pixels.push_back(px);
      endfunction

      function void push_color(input logic [BYTE_W-1:0] luma, input int du, input int dv,
                               input logic last);
         int base;
         base = int'(luma) << FRAC_BITS;
         push_pixel(saturate(base + RED_FROM_V * dv),
                    saturate(base - GREEN_FROM_U * du - GREEN_FROM_V * dv),
                    saturate(base + BLUE_FROM_U * du), last);
      endfunction

      function void note_request(input logic [BYTE_W-1:0] first_luma,
                                 input logic [BYTE_W-1:0] blue_chroma,
                                 input logic [BYTE_W-1:0] second_luma,
                                 input logic [BYTE_W-1:0] red_chroma);
         int du;
         int dv;
         if (gray_mode) begin
            push_pixel(first_luma, first_luma, first_luma, 1'b1);
            return;
         end
         du = int'(blue_chroma) - CHROMA_ZERO;
         dv = int'(red_chroma) - CHROMA_ZERO;
         push_color(first_luma, du, dv, 1'b0);
         push_color(second_luma, du, dv, 1'b1);
      endfunction

      function void check_pixel(input rgb_pixel_type got);
         rgb_pixel_type want;
         if (expected_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: pixel with nothing pending: %s", describe(got));
            return;
         end
         want = expected_pixels.pop_front();
         if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
             got.last_of_item !== want.last_of_item || got.end_of_line !== want.end_of_line ||
             got.end_of_frame !== want.end_of_frame) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: pixel differs\n  expected %s\n  actual   %s",
                        describe(want), describe(got));
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      function void flush_leftover();
         if (expected_pixels.size() != 0) begin
            $display("ERROR: %0d expected pixels never arrived", expected_pixels.size());
            mismatch_count += expected_pixels.size();
         end
      endfunction
   endclass

endpackage

FILE: dv/tb_yuyv_to_rgb_pixel_converter_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_yuyv_to_rgb_pixel_converter_top
// Self-checking bench: corner pairs and register settings first, then random
// YUYV pairs over several frame sizes and both modes, with random idling on
// the request side and back-pressure on the pixel side. Every pixel is
// compared with a bit-exact prediction of color, item and frame markers.
// ----------------------------------------------------------------------------
module tb_yuyv_to_rgb_pixel_converter_top;
   import yuyv2rgb_pkg::*;
   import yuyv_pixel_check_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 4;     // two-stage pipeline, plus margin
   localparam int LONG_HOLD     = 300;   // pixel-side hold-off to fill the block

   // corner pairs, packed as {Y0, U, Y1, V}
   localparam logic [31:0] CORNER_PAIRS [8] = '{
      32'h00_00_00_00, 32'hFF_FF_FF_FF, 32'h00_FF_00_00, 32'hFF_00_FF_FF,
      32'h80_80_80_80, 32'hFF_80_00_80, 32'h10_00_EB_FF, 32'hC8_FF_32_00
   };

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_first_luma = '0;
   logic [BYTE_W-1:0]     req_blue_chroma = '0;
   logic [BYTE_W-1:0]     req_second_luma = '0;
   logic [BYTE_W-1:0]     req_red_chroma = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [BYTE_W-1:0]     rsp_red;
   logic [BYTE_W-1:0]     rsp_green;
   logic [BYTE_W-1:0]     rsp_blue;
   logic                  rsp_last_of_item;
   logic                  rsp_end_of_line;
   logic                  rsp_end_of_frame;

   rgb_pixel_scoreboard board = new();

   int sender_idle_pct = 0;   // only the stimulus process uses this
   int stall_pct       = 0;   // read by the pixel sink
   int hold_ticket     = 0;   // bumped to request one long hold-off
   int cycle_count     = 0;

   yuyv_to_rgb_pixel_converter_top DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_first_luma   (req_first_luma),
      .req_blue_chroma  (req_blue_chroma),
      .req_second_luma  (req_second_luma),
      .req_red_chroma   (req_red_chroma),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_end_of_line  (rsp_end_of_line),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   // Pixel sink. Handshake is sampled with pre-edge values right after the
   // clock edge; rsp_ready for the next cycle is set with one NBA per edge.
   // A long hold-off is counted here so the stimulus side keeps pushing.
   initial begin
      int            hold_served;
      int            hold_left;
      rgb_pixel_type got;
      hold_served = 0;
      hold_left   = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.red          = rsp_red;
            got.green        = rsp_green;
            got.blue         = rsp_blue;
            got.last_of_item = rsp_last_of_item;
            got.end_of_line  = rsp_end_of_line;
            got.end_of_frame = rsp_end_of_frame;
            board.check_pixel(got);
         end
         if (hold_ticket != hold_served) begin
            hold_served = hold_ticket;
            hold_left   = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Bytes lean toward 0 and 255 so the clamps get hit often.
   function automatic logic [BYTE_W-1:0] random_byte();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return BYTE_W'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [31:0] random_pair();
      return {random_byte(), random_byte(), random_byte(), random_byte()};
   endfunction

   // One request transaction. Valid is held until accepted; a gap drops it
   // only when the sender decides to idle before the next pair.
   task automatic send_item(input logic [31:0] pair);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_first_luma, req_blue_chroma, req_second_luma, req_red_chroma} <= pair;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      board.note_request(pair[31:24], pair[23:16], pair[15:8], pair[7:0]);
   endtask

   // csr_valid stays high across back-to-back writes; caller lowers it.
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      board.write_register(index, data);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] gray_data,
                            input logic [CSR_DATA_W-1:0] width,
                            input logic [CSR_DATA_W-1:0] height);
      write_register(CSR_GRAY_MODE, gray_data);
      write_register(CSR_FRAME_WIDTH, width);
      write_register(CSR_FRAME_HEIGHT, height);
      csr_valid <= 1'b0;
   endtask

   // Every item yields at least one pixel, so an empty queue plus pipeline depth
   // means the block is idle and registers may be written.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] gray_data,
                            input logic [CSR_DATA_W-1:0] width,
                            input logic [CSR_DATA_W-1:0] height,
                            input int idle, input int stall, input int count,
                            input bit pressure);
      wait_until_idle();
      sender_idle_pct = idle;
      stall_pct <= stall;
      configure(gray_data, width, height);
      for (int i = 0; i < count; i++) begin
         if (pressure && i == 20)
            hold_ticket <= hold_ticket + 1;
         send_item(random_pair());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // --- directed part, reset settings first (color, 640x480) ---
      foreach (CORNER_PAIRS[i])
         send_item(CORNER_PAIRS[i]);

      // shrink the line while the column counter sits past the new width
      wait_until_idle();
      configure(13'd0, 13'd4, 13'd2);
      repeat (4) send_item(random_pair());

      // odd width in color mode: a pair straddles two lines
      wait_until_idle();
      configure(13'd0, 13'd3, 13'd2);
      repeat (3) send_item(random_pair());

      // gray mode, upper data bits set; zero size clamps to 2x1
      wait_until_idle();
      configure(13'h1FFF, 13'd0, 13'd0);
      send_item(32'h00_FF_FF_FF);
      send_item(32'hFF_00_00_00);
      send_item(32'h80_5A_A5_7F);
      send_item(random_pair());

      // unmapped index is a no-op; width 1 and oversized height clamp
      wait_until_idle();
      write_register(CSR_UNMAPPED, 13'h1555);
      configure(13'h1FFE, 13'd1, 13'h1FFF);
      repeat (3) send_item(random_pair());

      // --- random part: gray, width, height, idle %, stall %, count, pressure ---
      run_phase(13'd0, 13'd4,    13'd2,    0,  0,  100, 1'b1);
      run_phase(13'd0, 13'd6,    13'd3,    86, 0,  80,  1'b0);
      run_phase(13'd1, 13'd5,    13'd3,    0,  86, 80,  1'b0);
      run_phase(13'd0, 13'd3,    13'd2,    27, 27, 80,  1'b0);
      run_phase(13'd1, 13'd2,    13'd1,    0,  0,  60,  1'b1);
      run_phase(13'd0, 13'd4096, 13'd4096, 27, 27, 60,  1'b0);
      run_phase(13'd0, 13'h1FFF, 13'd0,    0,  86, 60,  1'b0);
      run_phase(13'd1, 13'd1,    13'h1FFF, 86, 0,  60,  1'b0);
      run_phase(13'd0, 13'd2,    13'd1,    27, 27, 80,  1'b0);

      // drain, then leave room for any stray pixel to show up
      wait_until_idle();
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      board.flush_leftover();
      if (board.mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/yuyv2rgb_pkg.sv
rtl/core/yuyv2rgb_front.sv
rtl/core/yuyv2rgb_pixel_math.sv
rtl/core/yuyv2rgb_position.sv
rtl/core/yuyv_to_rgb_pixel_converter_top.sv
dv/yuyv_pixel_check_pkg.sv
dv/tb_yuyv_to_rgb_pixel_converter_top.sv
